/* rtl/tpb_pkg.sv */
// Shared types and constants for the transparent pixel blit stream.
package tpb_pkg;

  localparam int CFG_DATA_W = 10;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 10;
  localparam int COORD_W    = 10;
  localparam int PIXEL_W    = 16;

  localparam logic [COL_W-1:0] WIDTH_RESET  = 9'd320;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 10'd240;

  localparam logic [PIXEL_W-1:0] OPAQUE_MASK = 16'h8000;
  localparam logic [PIXEL_W-1:0] RG_MASK     = 16'h7fe0;
  localparam logic [PIXEL_W-1:0] BLUE_MASK   = 16'h001f;

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_ORIGIN_X = 3'd1,
    REG_ORIGIN_Y = 3'd2,
    REG_WIDTH    = 3'd3,
    REG_HEIGHT   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic               transparent_mode;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COL_W-1:0]   window_width;
    logic [ROW_W-1:0]   window_height;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0] column_count;
    logic [ROW_W-1:0] row_count;
    logic             gap_pending;
    logic             row_had_gap;
  } state_t;

  typedef struct packed {
    logic               positioned;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [PIXEL_W-1:0] color;
    logic               window_done;
  } result_t;

endpackage

/* rtl/tpb_step.sv */
// Per-pixel logic: window position, gap tracking and 1555 to 565 conversion.
module tpb_step #(
  parameter int MAX_ROW_PIXELS = 320
) (
  input  tpb_pkg::cfg_t                     cfg,
  input  tpb_pkg::state_t                   state,
  input  logic [tpb_pkg::PIXEL_W-1:0]       pixel,
  output tpb_pkg::state_t                   state_nxt,
  output tpb_pkg::result_t                  result,
  output logic                              emit
);
  import tpb_pkg::*;

  // Width port is 9 bits, so a limit above 511 never clamps.
  localparam int WMAX = (MAX_ROW_PIXELS > 511) ? 511 : MAX_ROW_PIXELS;

  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             last_col;
  logic             last_row;
  logic             done;
  logic             gap;
  logic             row_gap;

  always_comb begin
    if (cfg.window_width == '0) begin
      eff_w = COL_W'(1);
    end else if (cfg.window_width > COL_W'(WMAX)) begin
      eff_w = COL_W'(WMAX);
    end else begin
      eff_w = cfg.window_width;
    end
    eff_h = (cfg.window_height == '0) ? ROW_W'(1) : cfg.window_height;
  end

  assign last_col = ({1'b0, state.column_count} + (COL_W+1)'(1)) >= {1'b0, eff_w};
  assign last_row = ({1'b0, state.row_count} + (ROW_W+1)'(1)) >= {1'b0, eff_h};
  assign done     = last_col && last_row;

  always_comb begin
    gap     = state.gap_pending;
    row_gap = state.row_had_gap;
    emit    = 1'b1;

    result.positioned  = 1'b0;
    result.pos_x       = cfg.origin_x + {1'b0, state.column_count};
    result.pos_y       = cfg.origin_y + eff_h - state.row_count - COORD_W'(1);
    result.color       = pixel;
    result.window_done = done;

    // Row start: pick up the previous row's gap flag.
    if (state.column_count == '0) begin
      gap     = state.row_had_gap;
      row_gap = 1'b0;
    end

    if (cfg.transparent_mode) begin
      if ((pixel & OPAQUE_MASK) != '0) begin
        result.color = ((pixel & RG_MASK) << 1) | (pixel & BLUE_MASK);
        if (gap) begin
          result.positioned = 1'b1;
          gap               = 1'b0;
        end
      end else begin
        // Drop the word and mark the gap.
        emit    = 1'b0;
        gap     = 1'b1;
        row_gap = 1'b1;
      end
    end

    if (done) begin
      state_nxt.column_count = '0;
      state_nxt.row_count    = '0;
      state_nxt.gap_pending  = 1'b0;
      state_nxt.row_had_gap  = 1'b0;
    end else if (last_col) begin
      state_nxt.column_count = '0;
      state_nxt.row_count    = state.row_count + ROW_W'(1);
      state_nxt.gap_pending  = gap;
      state_nxt.row_had_gap  = row_gap;
    end else begin
      state_nxt.column_count = state.column_count + COL_W'(1);
      state_nxt.row_count    = state.row_count;
      state_nxt.gap_pending  = gap;
      state_nxt.row_had_gap  = row_gap;
    end
  end

endmodule

/* rtl/transparent_pixel_blit_stream_top.sv */
// Top level of the transparent pixel blit stream.
//
// Takes window pixels (rows bottom first, left to right) on the in_ channel
// and issues display write commands on the out_ channel. Both channels use
// valid/stall: a word moves on a rising edge with valid high and stall low.
// Each input word is registered, then converted in one pass into the output
// register, which drives out_valid. One word per cycle is sustained while
// out_stall stays low; the only loop is the update of the window counters
// and gap flags in the compute stage.
// In transparent mode a pixel with bit 15 clear yields no output word.
// When out_stall is high the output word holds and in_stall rises once the
// input register also holds a word to emit; nothing is lost.
// The user must write registers through cfg_wr_en/cfg_index/cfg_data only
// while the block is idle; the block does not enforce this. Synchronous
// reset (rst_n low) empties both stages, clears counters and flags and loads
// the register reset values (plain mode, origin 0,0, window 320 x 240).
module transparent_pixel_blit_stream_top #(
  parameter int MAX_ROW_PIXELS = 320
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [2:0]                     cfg_index,
  input  logic [tpb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tpb_pkg::PIXEL_W-1:0]    in_pixel,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_positioned,
  output logic [tpb_pkg::COORD_W-1:0]    out_pos_x,
  output logic [tpb_pkg::COORD_W-1:0]    out_pos_y,
  output logic [tpb_pkg::PIXEL_W-1:0]    out_color,
  output logic                           out_window_done
);
  import tpb_pkg::*;

  cfg_t               cfg_r;
  state_t             state_r;
  state_t             state_nxt;
  logic               s1_valid_r;
  logic [PIXEL_W-1:0] s1_pixel_r;
  logic               out_valid_r;
  result_t            out_r;
  result_t            result;
  logic               emit;
  logic               out_free;
  logic               s1_adv;
  logic               in_take;

  tpb_step #(
    .MAX_ROW_PIXELS(MAX_ROW_PIXELS)
  ) u_step (
    .cfg       (cfg_r),
    .state     (state_r),
    .pixel     (s1_pixel_r),
    .state_nxt (state_nxt),
    .result    (result),
    .emit      (emit)
  );

  assign out_free = !out_valid_r || !out_stall;
  // A dropped pixel needs no room at the output.
  assign s1_adv   = s1_valid_r && (out_free || !emit);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.transparent_mode <= 1'b0;
      cfg_r.origin_x         <= '0;
      cfg_r.origin_y         <= '0;
      cfg_r.window_width     <= WIDTH_RESET;
      cfg_r.window_height    <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MODE:     cfg_r.transparent_mode <= cfg_data[0];
        REG_ORIGIN_X: cfg_r.origin_x         <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y: cfg_r.origin_y         <= cfg_data[COORD_W-1:0];
        REG_WIDTH:    cfg_r.window_width     <= cfg_data[COL_W-1:0];
        REG_HEIGHT:   cfg_r.window_height    <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        state_r <= state_nxt;
      end
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pixel_r <= in_pixel;
    end
    if (s1_adv && emit) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_positioned  = out_r.positioned;
  assign out_pos_x       = out_r.pos_x;
  assign out_pos_y       = out_r.pos_y;
  assign out_color       = out_r.color;
  assign out_window_done = out_r.window_done;

  // Column count never reaches the all-ones code (width is at most 511).
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.column_count != {COL_W{1'b1}})
    else $error("column count out of range");

  // A delivered window end leaves counters and flags cleared.
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit && result.window_done |=>
      state_r.column_count == '0 && state_r.row_count == '0 &&
      !state_r.gap_pending && !state_r.row_had_gap)
    else $error("window end did not clear state");

  // Pixels are dropped only in transparent mode.
  a_drop_mode: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && !emit |-> cfg_r.transparent_mode)
    else $error("pixel dropped in plain mode");

  // An emitted pixel lands in the output register on the next edge.
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && emit |=> out_valid_r)
    else $error("emitted word lost");

endmodule

/* tb/transparent_pixel_blit_stream_top_test.sv */
// Self-checking testbench for the transparent pixel blit stream top level.
`timescale 1ns / 100ps

module transparent_pixel_blit_stream_top_test;
  import tpb_pkg::*;

  localparam int ROW_LIMIT  = 320;
  localparam int DRAIN      = 6;
  localparam int HOLD_LEN   = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_GOAL  = 850;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [2:0]            cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    in_pixel  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_positioned;
  logic [COORD_W-1:0]    out_pos_x;
  logic [COORD_W-1:0]    out_pos_y;
  logic [PIXEL_W-1:0]    out_color;
  logic                  out_window_done;

  transparent_pixel_blit_stream_top #(.MAX_ROW_PIXELS(ROW_LIMIT)) uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_positioned(out_positioned), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
    .out_color(out_color), .out_window_done(out_window_done)
  );

  // Shadow copy of the registers and the window state.
  logic               mode_sh  = 1'b0;
  logic [COORD_W-1:0] org_x_sh = '0;
  logic [COORD_W-1:0] org_y_sh = '0;
  logic [COL_W-1:0]   win_w_sh = WIDTH_RESET;
  logic [ROW_W-1:0]   win_h_sh = HEIGHT_RESET;
  logic [COL_W-1:0]   col_cnt  = '0;
  logic [ROW_W-1:0]   row_cnt  = '0;
  logic               gap_flag = 1'b0;
  logic               row_gap  = 1'b0;

  logic [PIXEL_W-1:0] pixel_q[$];
  result_t            cmd_q[$];
  result_t            next_cmd;
  int                 pushed_cnt  = 0;
  int                 sent_cnt    = 0;
  int                 errors      = 0;
  int                 idle_cycles = 0;
  int                 hold_left   = 0;
  bit                 hold_req    = 1'b0;
  bit                 hold_done   = 1'b0;
  bit                 steady      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int eff_width();
    if (win_w_sh == 0) return 1;
    if (win_w_sh > ROW_LIMIT) return ROW_LIMIT;
    return win_w_sh;
  endfunction

  function automatic int eff_height();
    return (win_h_sh == 0) ? 1 : win_h_sh;
  endfunction

  // Work out the display command for one pixel and advance the window state.
  function automatic bit blit_pixel(input logic [PIXEL_W-1:0] p, output result_t cmd);
    int w, h, col, row;
    bit last_col, last_row, emit;
    w = eff_width();
    h = eff_height();
    col = col_cnt;
    row = row_cnt;
    last_col = (col + 1) >= w;
    last_row = (row + 1) >= h;
    emit = 1'b1;
    cmd.positioned  = 1'b0;
    cmd.pos_x       = COORD_W'(org_x_sh + col);
    cmd.pos_y       = COORD_W'(org_y_sh + h - row - 1);
    cmd.color       = p;
    cmd.window_done = last_col && last_row;
    // row start: inherit the previous row's gap
    if (col == 0) begin
      gap_flag = row_gap;
      row_gap  = 1'b0;
    end
    if (mode_sh) begin
      if ((p & OPAQUE_MASK) != 0) begin
        cmd.color = ((p & RG_MASK) << 1) | (p & BLUE_MASK);
        if (gap_flag) begin
          cmd.positioned = 1'b1;
          gap_flag = 1'b0;
        end
      end else begin
        emit = 1'b0;
        gap_flag = 1'b1;
        row_gap  = 1'b1;
      end
    end
    if (last_col && last_row) begin
      col_cnt  = '0;
      row_cnt  = '0;
      gap_flag = 1'b0;
      row_gap  = 1'b0;
    end else if (last_col) begin
      col_cnt = '0;
      row_cnt = ROW_W'(row + 1);
    end else begin
      col_cnt = COL_W'(col + 1);
    end
    return emit;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  // Driver: hold a stalled word, otherwise load the next pending pixel or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (blit_pixel(in_pixel, next_cmd)) cmd_q.push_back(next_cmd);
        sent_cnt++;
      end
      if (!in_valid || !in_stall) begin
        if (pixel_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
          in_valid <= 1'b1;
          in_pixel <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each command word against the oldest prediction and drive out_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_q.size() == 0) begin
          report_mismatch("command word with nothing predicted");
        end else begin
          next_cmd = cmd_q.pop_front();
          compare_field("positioned", out_positioned, next_cmd.positioned);
          compare_field("pos_x", out_pos_x, next_cmd.pos_x);
          compare_field("pos_y", out_pos_y, next_cmd.pos_y);
          compare_field("color", out_color, next_cmd.color);
          compare_field("window_done", out_window_done, next_cmd.window_done);
        end
      end
      if (hold_req && !hold_done) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 9);
      end
    end
  end

  // Watchdog: end the run when neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic push_pixel(input logic [PIXEL_W-1:0] p);
    pixel_q.push_back(p);
    pushed_cnt++;
  endtask

  task automatic push_random(input int n, input int drop_pct);
    logic [PIXEL_W-1:0] p;
    for (int i = 0; i < n; i++) begin
      p = PIXEL_W'($urandom);
      if (mode_sh) p[15] = ($urandom_range(99) >= drop_pct);
      push_pixel(p);
    end
  endtask

  // Wait until every pixel is taken and every command has come, then drain.
  task automatic wait_idle();
    while (sent_cnt != pushed_cnt || cmd_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input int value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    case (idx)
      REG_MODE:     mode_sh  = value[0];
      REG_ORIGIN_X: org_x_sh = COORD_W'(value);
      REG_ORIGIN_Y: org_y_sh = COORD_W'(value);
      REG_WIDTH:    win_w_sh = COL_W'(value);
      REG_HEIGHT:   win_h_sh = ROW_W'(value);
      default: ;
    endcase
  endtask

  task automatic apply_cfg(input int mode, input int ox, input int oy, input int w,
                           input int h);
    wait_idle();
    set_reg(REG_MODE, mode);
    set_reg(REG_ORIGIN_X, ox);
    set_reg(REG_ORIGIN_Y, oy);
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_origin();
    case ($urandom_range(3))
      0: return 0;
      1: return 1023;
      default: return $urandom_range(1023);
    endcase
  endfunction

  initial begin
    int phase, n, w, h, drop_pct, mode, ox, oy;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // wrapped origin, gaps within a row and from the row below, dropped last pixel
    apply_cfg(1, 1023, 1023, 3, 2);
    push_pixel(16'h8000); push_pixel(16'h7fff); push_pixel(16'hffff);
    push_pixel(16'hffff); push_pixel(16'h8001); push_pixel(16'h0000);
    push_pixel(16'haaaa); push_pixel(16'hd555); push_pixel(16'h8000);
    // plain mode, zero width and height count as one
    apply_cfg(0, 0, 0, 0, 0);
    push_pixel(16'h0000); push_pixel(16'hffff); push_pixel(16'h5a5a);
    // oversize width saturates; then shrink the window mid-row
    apply_cfg(1, 512, 0, 511, 1);
    push_pixel(16'h8421); push_pixel(16'h0001); push_pixel(16'hfc00);
    push_pixel(16'h83e0); push_pixel(16'h801f);
    apply_cfg(1, 512, 0, 2, 1);
    push_pixel(16'hbeef); push_pixel(16'h1234); push_pixel(16'h9abc);
    // mode changes mid-window keep the gap flag
    apply_cfg(1, 0, 1023, 4, 1);
    push_pixel(16'h0000);
    apply_cfg(0, 0, 1023, 4, 1);
    push_pixel(16'h1111); push_pixel(16'h8888);
    apply_cfg(1, 0, 1023, 4, 1);
    push_pixel(16'hc000);

    phase = 0;
    while (pushed_cnt < ITEM_GOAL) begin
      mode = ($urandom_range(3) != 0);
      ox = pick_origin();
      oy = pick_origin();
      case ($urandom_range(9))
        0: w = 0;
        1: w = 1;
        2: w = 320;
        3: w = 511;
        4: w = $urandom_range(321, 511);
        default: w = $urandom_range(2, 8);
      endcase
      case ($urandom_range(7))
        0: h = 0;
        1: h = 1;
        2: h = 1023;
        default: h = $urandom_range(2, 5);
      endcase
      case ($urandom_range(4))
        0: drop_pct = 0;
        1: drop_pct = 10;
        2: drop_pct = 30;
        3: drop_pct = 60;
        default: drop_pct = 95;
      endcase
      apply_cfg(mode, ox, oy, w, h);
      steady = (phase == 6 || phase == 7);
      // whole windows most of the time, sometimes with a ragged tail
      if (eff_width() * eff_height() <= 40) begin
        n = eff_width() * eff_height() * $urandom_range(2, 6);
        if ($urandom_range(3) == 0) n += $urandom_range(1, 5);
      end else begin
        n = $urandom_range(30, 90);
      end
      if (phase == 3) n += 40;
      // stop close to the item goal
      if (n > ITEM_GOAL - pushed_cnt) n = ITEM_GOAL - pushed_cnt;
      push_random(n, drop_pct);
      if (phase == 3) hold_req = 1'b1;
      phase++;
    end

    wait_idle();
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
